>>> src/arcade_input_sampler_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the arcade input sampler
// Shared concurrent assertion forms, clocked and disabled by reset.
// ---------------------------------------------------------------------------
`ifndef ARCADE_INPUT_SAMPLER_TOP_ASSERT_SVH
`define ARCADE_INPUT_SAMPLER_TOP_ASSERT_SVH

// Same-cycle implication.
`define AIS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ais_pkg.sv
// ---------------------------------------------------------------------------
// ais_pkg
// Widths, codes and result type of the arcade input sampler.
// ---------------------------------------------------------------------------
package ais_pkg;

  localparam int BYTE_W    = 8;
  localparam int FUNC_W    = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 1;
  localparam int NUM_SW    = 5;

  localparam logic [BYTE_W-1:0] DRIVE_MASK = 8'hF0;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SAMPLE = 3'd0,
    FUNC_SYNC   = 3'd1,
    FUNC_ADD    = 3'd2,
    FUNC_SUB    = 3'd3,
    FUNC_DRIVE  = 3'd4
  } ais_func_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MAHJONG_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALT_SWAP     = 1'd1;

  typedef struct packed {
    logic [BYTE_W-1:0] system_byte;
    logic [BYTE_W-1:0] player_one_byte;
    logic [BYTE_W-1:0] player_one_extra;
    logic [BYTE_W-1:0] player_two_byte;
    logic [BYTE_W-1:0] player_two_extra;
    logic [BYTE_W-1:0] coin_one_count;
    logic [BYTE_W-1:0] coin_two_count;
    logic [BYTE_W-1:0] drive_enable;
  } ais_result_t;

endpackage

>>> src/ais_in_if.sv
// ---------------------------------------------------------------------------
// ais_in_if
// Command channel of the arcade input sampler: valid/ready plus one command.
// ---------------------------------------------------------------------------
interface ais_in_if
  import ais_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [BYTE_W-1:0] port_a_pins;
  logic [BYTE_W-1:0] port_b_pins;
  logic [BYTE_W-1:0] port_c_pins;
  logic [BYTE_W-1:0] port_d_pins;
  logic              swap_buttons;
  logic              coin_slot;
  logic [BYTE_W-1:0] coin_amount;
  logic              rapid_enable;
  logic              rapid_suppress;
  logic [BYTE_W-1:0] drive_request;

  modport source (
    output valid, func, port_a_pins, port_b_pins, port_c_pins, port_d_pins,
           swap_buttons, coin_slot, coin_amount, rapid_enable, rapid_suppress,
           drive_request,
    input  ready
  );

  modport sink (
    input  valid, func, port_a_pins, port_b_pins, port_c_pins, port_d_pins,
           swap_buttons, coin_slot, coin_amount, rapid_enable, rapid_suppress,
           drive_request,
    output ready
  );
endinterface

>>> src/ais_out_if.sv
// ---------------------------------------------------------------------------
// ais_out_if
// Snapshot channel of the arcade input sampler: valid/ready plus one snapshot.
// ---------------------------------------------------------------------------
interface ais_out_if
  import ais_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] system_byte;
  logic [BYTE_W-1:0] player_one_byte;
  logic [BYTE_W-1:0] player_one_extra;
  logic [BYTE_W-1:0] player_two_byte;
  logic [BYTE_W-1:0] player_two_extra;
  logic [BYTE_W-1:0] coin_one_count;
  logic [BYTE_W-1:0] coin_two_count;
  logic [BYTE_W-1:0] drive_enable;

  modport source (
    output valid, system_byte, player_one_byte, player_one_extra,
           player_two_byte, player_two_extra, coin_one_count, coin_two_count,
           drive_enable,
    input  ready
  );

  modport sink (
    input  valid, system_byte, player_one_byte, player_one_extra,
           player_two_byte, player_two_extra, coin_one_count, coin_two_count,
           drive_enable,
    output ready
  );
endinterface

>>> src/arcade_input_sampler_top.sv
// ---------------------------------------------------------------------------
// Arcade input sampler
// in_ch carries one command transaction (pin sample, frame sync, coin add,
// coin subtract, output drive); each command yields exactly one snapshot
// transaction on out_ch: five switch bytes with the rapid fold, both coin
// counters and the port C drive bits. cfg_we/cfg_index/cfg_wdata set the
// mahjong mode and the alternate swap map; write them only while idle.
// Snapshots are registered, via the skid register while out_ch is stalled.
// Throughput: one command per clock while in_ch.ready is high; all decode,
// counter and remap logic sits between the channel and the snapshot register.
// Stall: a skid register behind the snapshot register keeps in_ch.ready high
// for one more transaction while out_ch is stalled; with both full, ready
// drops until out_ch takes a snapshot.
// Reset (rst_n low, synchronous): both channels empty, coin latches and
// previous levels high, counters, switch bytes and drive bits zero, both
// mode registers cleared.
// ---------------------------------------------------------------------------
`include "arcade_input_sampler_top_assert.svh"

module arcade_input_sampler_top
  import ais_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  ais_in_if.sink               in_ch,
  ais_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  // Mode registers
  logic mahjong_r;
  logic alt_swap_r;

  // Block state
  logic [1:0]        latch_r,  latch_nxt;     // coin line seen low this frame
  logic [1:0]        prev_r,   prev_nxt;      // latch value of last frame
  logic [BYTE_W-1:0] coin_r    [2];
  logic [BYTE_W-1:0] coin_nxt  [2];
  logic [BYTE_W-1:0] sw_r      [NUM_SW];
  logic [BYTE_W-1:0] sw_nxt    [NUM_SW];
  logic [BYTE_W-1:0] drive_r,  drive_nxt;

  // Output register and skid register
  logic        out_v_r;
  ais_result_t out_r;
  logic        skid_v_r;
  ais_result_t skid_r;

  ais_result_t res;
  ais_func_t   func;
  logic        accept;
  logic        load_out;

  logic [15:0] p1_pair;
  logic [15:0] p2_pair;
  logic [BYTE_W-1:0] dirs1, dirs2;

  // Remap one player port into {main byte, extra byte}. Pins are active low.
  function automatic logic [15:0] player_bytes(input logic [BYTE_W-1:0] p,
                                               input logic start,
                                               input logic [BYTE_W-1:0] dirs,
                                               input logic swap,
                                               input logic alt);
    logic [BYTE_W-1:0] m;
    logic [BYTE_W-1:0] e;
    m = {~p[1], start, 6'b0} | dirs;
    e = {2'b00, ~p[6], ~p[7], 4'b0};
    if (swap && alt) begin
      m[1:0] = {~p[3], ~p[4]};
      e[7:6] = {~p[5], ~p[2]};
    end else if (swap) begin
      m[1:0] = {~p[5], ~p[2]};
      e[7:6] = {~p[3], ~p[4]};
    end else begin
      m[1:0] = {~p[2], ~p[3]};
      e[7:6] = {~p[4], ~p[5]};
    end
    return {m, e};
  endfunction

  assign func   = ais_func_t'(in_ch.func);
  assign accept = in_ch.valid && in_ch.ready;

  // Skid slot free means one more transaction can land somewhere.
  assign in_ch.ready = !skid_v_r;

  // Direction bits: port A low nibble for player one, high nibble for two.
  assign dirs1 = {2'b00, ~in_ch.port_a_pins[0], ~in_ch.port_a_pins[1],
                  ~in_ch.port_a_pins[2], ~in_ch.port_a_pins[3], 2'b00};
  assign dirs2 = {2'b00, ~in_ch.port_a_pins[4], ~in_ch.port_a_pins[5],
                  ~in_ch.port_a_pins[6], ~in_ch.port_a_pins[7], 2'b00};

  assign p1_pair = player_bytes(in_ch.port_b_pins, ~in_ch.port_d_pins[1], dirs1,
                                in_ch.swap_buttons, alt_swap_r);
  assign p2_pair = player_bytes(in_ch.port_c_pins, 1'b0, dirs2,
                                in_ch.swap_buttons, alt_swap_r);

  // Command decode and state update
  always_comb begin
    latch_nxt = latch_r;
    prev_nxt  = prev_r;
    coin_nxt  = coin_r;
    sw_nxt    = sw_r;
    drive_nxt = drive_r;
    unique case (func)
      FUNC_SAMPLE: begin
        latch_nxt = latch_r & {in_ch.port_c_pins[0], in_ch.port_b_pins[0]};
        sw_nxt[0] = {~in_ch.port_d_pins[4], 7'b0};
        sw_nxt[1] = p1_pair[15:8];
        if (mahjong_r) begin
          sw_nxt[2] = '0;
          sw_nxt[3] = '0;
          sw_nxt[4] = '0;
        end else begin
          sw_nxt[2] = p1_pair[7:0];
          sw_nxt[3] = p2_pair[15:8];
          sw_nxt[4] = p2_pair[7:0];
        end
      end
      FUNC_SYNC: begin
        // A coin counts when the line was held last frame and released now.
        for (int i = 0; i < 2; i++) begin
          if (!prev_r[i] && latch_r[i]) begin
            coin_nxt[i] = coin_r[i] + 8'd1;
          end
        end
        prev_nxt  = latch_r;
        latch_nxt = 2'b11;
      end
      FUNC_ADD: begin
        coin_nxt[in_ch.coin_slot] = coin_r[in_ch.coin_slot] + in_ch.coin_amount;
      end
      FUNC_SUB: begin
        coin_nxt[in_ch.coin_slot] = coin_r[in_ch.coin_slot] - in_ch.coin_amount;
      end
      FUNC_DRIVE: begin
        // Upper nibble rotated right by one within the nibble.
        if (mahjong_r) begin
          drive_nxt = {in_ch.drive_request[4], in_ch.drive_request[7:5], 4'b0}
                      & DRIVE_MASK;
        end
      end
      default: begin
      end
    endcase
  end

  // Snapshot with the rapid fold
  always_comb begin
    res.system_byte      = sw_nxt[0];
    res.player_one_byte  = sw_nxt[1];
    res.player_one_extra = sw_nxt[2];
    res.player_two_byte  = sw_nxt[3];
    res.player_two_extra = sw_nxt[4];
    if (in_ch.rapid_enable && !in_ch.rapid_suppress) begin
      res.player_one_byte[1:0] = sw_nxt[1][1:0] | sw_nxt[2][6:5];
      res.player_one_extra[7]  = sw_nxt[2][7] | sw_nxt[2][4];
      res.player_two_byte[1:0] = sw_nxt[3][1:0] | sw_nxt[4][6:5];
      res.player_two_extra[7]  = sw_nxt[4][7] | sw_nxt[4][4];
    end
    res.coin_one_count = coin_nxt[0];
    res.coin_two_count = coin_nxt[1];
    res.drive_enable   = drive_nxt;
  end

  assign load_out = !out_v_r || out_ch.ready;

  // Mode registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mahjong_r  <= 1'b0;
      alt_swap_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAHJONG_MODE: mahjong_r  <= cfg_wdata[0];
        CFG_ALT_SWAP:     alt_swap_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= 2'b11;
      prev_r  <= 2'b11;
      coin_r  <= '{default: '0};
      sw_r    <= '{default: '0};
      drive_r <= '0;
    end else if (accept) begin
      latch_r <= latch_nxt;
      prev_r  <= prev_nxt;
      coin_r  <= coin_nxt;
      sw_r    <= sw_nxt;
      drive_r <= drive_nxt;
    end
  end

  // Output and skid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (load_out) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (accept) begin
      if (load_out) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (load_out) begin
        out_r <= skid_r;
      end
    end else if (accept) begin
      if (load_out) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_ch.valid            = out_v_r;
  assign out_ch.system_byte      = out_r.system_byte;
  assign out_ch.player_one_byte  = out_r.player_one_byte;
  assign out_ch.player_one_extra = out_r.player_one_extra;
  assign out_ch.player_two_byte  = out_r.player_two_byte;
  assign out_ch.player_two_extra = out_r.player_two_extra;
  assign out_ch.coin_one_count   = out_r.coin_one_count;
  assign out_ch.coin_two_count   = out_r.coin_two_count;
  assign out_ch.drive_enable     = out_r.drive_enable;

  // Checks
  `AIS_ASSERT_IMPLY(a_skid_behind_out, clk, rst_n, skid_v_r, out_v_r,
    "skid register holds a snapshot while the output register is empty")
  `AIS_ASSERT_NEXT(a_stall_fills_skid, clk, rst_n,
    accept && out_v_r && !out_ch.ready, skid_v_r,
    "transaction taken under stall did not land in the skid register")
  `AIS_ASSERT_NEXT(a_drive_only_mahjong, clk, rst_n, rst_n && !mahjong_r,
    $stable(drive_r), "drive bits changed outside mahjong mode")
  `AIS_ASSERT_NEXT(a_mahjong_clears, clk, rst_n,
    accept && func == FUNC_SAMPLE && mahjong_r,
    sw_r[2] == '0 && sw_r[3] == '0 && sw_r[4] == '0,
    "mahjong sample left switch bytes 2 to 4 nonzero")
  `AIS_ASSERT_NEXT(a_sync_one_coin, clk, rst_n, accept && func == FUNC_SYNC,
    coin_r[0] == $past(coin_r[0]) || coin_r[0] == 8'($past(coin_r[0]) + 8'd1),
    "frame sync moved coin counter one by more than one")

endmodule

>>> tb/ais_snapshot_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ais_snapshot_checker
// Watches the command, snapshot and register ports of the arcade input
// sampler, predicts every snapshot and compares it field by field.
// ---------------------------------------------------------------------------
module ais_snapshot_checker
  import ais_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  ais_in_if                    in_mon,
  ais_out_if                   out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  output int                   fail_count,
  output int                   pending_count
);

  logic              mahjong_q;
  logic              alt_swap_q;
  logic              coin_latch_q [2];
  logic              coin_prev_q  [2];
  logic [BYTE_W-1:0] coin_total_q [2];
  logic [BYTE_W-1:0] switch_q     [NUM_SW];
  logic [BYTE_W-1:0] drive_q;

  ais_result_t snapshot_q [$];
  int          err_cnt;

  // Active-low pin: val when the masked pin is low.
  function automatic logic [BYTE_W-1:0] pin_low(input logic [BYTE_W-1:0] pins,
                                                input logic [BYTE_W-1:0] mask,
                                                input logic [BYTE_W-1:0] val);
    return ((pins & mask) != '0) ? '0 : val;
  endfunction

  // Main and extra switch bytes of one player.
  function automatic void player_pair(input  logic [BYTE_W-1:0] p,
                                      input  logic [BYTE_W-1:0] start,
                                      input  logic [BYTE_W-1:0] dirs,
                                      input  logic              swap,
                                      output logic [BYTE_W-1:0] main_b,
                                      output logic [BYTE_W-1:0] extra_b);
    logic [BYTE_W-1:0] m;
    logic [BYTE_W-1:0] e;
    m = pin_low(p, 8'h02, 8'h80) | start | dirs;
    e = pin_low(p, 8'h40, 8'h20) | pin_low(p, 8'h80, 8'h10);
    if (swap && alt_swap_q) begin
      m |= pin_low(p, 8'h08, 8'h02) | pin_low(p, 8'h10, 8'h01);
      e |= pin_low(p, 8'h20, 8'h80) | pin_low(p, 8'h04, 8'h40);
    end else if (swap) begin
      m |= pin_low(p, 8'h20, 8'h02) | pin_low(p, 8'h04, 8'h01);
      e |= pin_low(p, 8'h08, 8'h80) | pin_low(p, 8'h10, 8'h40);
    end else begin
      m |= pin_low(p, 8'h04, 8'h02) | pin_low(p, 8'h08, 8'h01);
      e |= pin_low(p, 8'h10, 8'h80) | pin_low(p, 8'h20, 8'h40);
    end
    main_b  = m;
    extra_b = e;
  endfunction

  function automatic ais_result_t predict_snapshot(input logic [FUNC_W-1:0] func,
                                                   input logic [BYTE_W-1:0] pa,
                                                   input logic [BYTE_W-1:0] pb,
                                                   input logic [BYTE_W-1:0] pc,
                                                   input logic [BYTE_W-1:0] pd,
                                                   input logic              swap,
                                                   input logic              slot,
                                                   input logic [BYTE_W-1:0] amount,
                                                   input logic              rapid,
                                                   input logic              suppress,
                                                   input logic [BYTE_W-1:0] req);
    ais_result_t       r;
    logic [BYTE_W-1:0] m;
    logic [BYTE_W-1:0] e;
    logic [BYTE_W-1:0] dirs;
    logic [BYTE_W-1:0] nib;
    case (func)
      FUNC_SAMPLE: begin
        coin_latch_q[0] &= pb[0];
        coin_latch_q[1] &= pc[0];
        switch_q[0] = pin_low(pd, 8'h10, 8'h80);
        dirs = pin_low(pa, 8'h01, 8'h20) | pin_low(pa, 8'h02, 8'h10) |
               pin_low(pa, 8'h04, 8'h08) | pin_low(pa, 8'h08, 8'h04);
        player_pair(pb, pin_low(pd, 8'h02, 8'h40), dirs, swap, m, e);
        switch_q[1] = m;
        if (mahjong_q) begin
          switch_q[2] = '0;
          switch_q[3] = '0;
          switch_q[4] = '0;
        end else begin
          switch_q[2] = e;
          dirs = pin_low(pa, 8'h10, 8'h20) | pin_low(pa, 8'h20, 8'h10) |
                 pin_low(pa, 8'h40, 8'h08) | pin_low(pa, 8'h80, 8'h04);
          player_pair(pc, '0, dirs, swap, m, e);
          switch_q[3] = m;
          switch_q[4] = e;
        end
      end
      FUNC_SYNC: begin
        // count a release: low last frame, high this frame
        for (int i = 0; i < 2; i++) begin
          if (!coin_prev_q[i] && coin_latch_q[i]) coin_total_q[i] += 8'd1;
          coin_prev_q[i]  = coin_latch_q[i];
          coin_latch_q[i] = 1'b1;
        end
      end
      FUNC_ADD: coin_total_q[slot] += amount;
      FUNC_SUB: coin_total_q[slot] -= amount;
      FUNC_DRIVE: begin
        if (mahjong_q) begin
          nib     = req & DRIVE_MASK;
          drive_q = ((nib >> 1) | (nib << 3)) & DRIVE_MASK;
        end
      end
      default: ;
    endcase

    r.system_byte      = switch_q[0];
    r.player_one_byte  = switch_q[1];
    r.player_one_extra = switch_q[2];
    r.player_two_byte  = switch_q[3];
    r.player_two_extra = switch_q[4];
    if (rapid && !suppress) begin
      r.player_one_byte  |= (switch_q[2] >> 5) & 8'h03;
      r.player_two_byte  |= (switch_q[4] >> 5) & 8'h03;
      r.player_one_extra |= (switch_q[2] << 3) & 8'h80;
      r.player_two_extra |= (switch_q[4] << 3) & 8'h80;
    end
    r.coin_one_count = coin_total_q[0];
    r.coin_two_count = coin_total_q[1];
    r.drive_enable   = drive_q;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [BYTE_W-1:0] exp_v,
                                      input logic [BYTE_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("[%0t] %s mismatch: expected %02h, got %02h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    ais_result_t exp_r;
    if (!rst_n) begin
      mahjong_q  = 1'b0;
      alt_swap_q = 1'b0;
      for (int i = 0; i < 2; i++) begin
        coin_latch_q[i] = 1'b1;
        coin_prev_q[i]  = 1'b1;
        coin_total_q[i] = '0;
      end
      for (int i = 0; i < NUM_SW; i++) switch_q[i] = '0;
      drive_q = '0;
      snapshot_q.delete();
      err_cnt = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAHJONG_MODE: mahjong_q  = cfg_wdata[0];
          CFG_ALT_SWAP:     alt_swap_q = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        snapshot_q.push_back(predict_snapshot(in_mon.func, in_mon.port_a_pins,
                                              in_mon.port_b_pins, in_mon.port_c_pins,
                                              in_mon.port_d_pins, in_mon.swap_buttons,
                                              in_mon.coin_slot, in_mon.coin_amount,
                                              in_mon.rapid_enable, in_mon.rapid_suppress,
                                              in_mon.drive_request));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (snapshot_q.size() == 0) begin
          $display("[%0t] unexpected snapshot: expected none, got %02h %02h %02h %02h %02h",
                   $time, out_mon.system_byte, out_mon.player_one_byte,
                   out_mon.player_one_extra, out_mon.player_two_byte,
                   out_mon.player_two_extra);
          err_cnt++;
        end else begin
          exp_r = snapshot_q.pop_front();
          check_field("system_byte",      exp_r.system_byte,      out_mon.system_byte);
          check_field("player_one_byte",  exp_r.player_one_byte,  out_mon.player_one_byte);
          check_field("player_one_extra", exp_r.player_one_extra, out_mon.player_one_extra);
          check_field("player_two_byte",  exp_r.player_two_byte,  out_mon.player_two_byte);
          check_field("player_two_extra", exp_r.player_two_extra, out_mon.player_two_extra);
          check_field("coin_one_count",   exp_r.coin_one_count,   out_mon.coin_one_count);
          check_field("coin_two_count",   exp_r.coin_two_count,   out_mon.coin_two_count);
          check_field("drive_enable",     exp_r.drive_enable,     out_mon.drive_enable);
        end
      end
    end
    fail_count    <= err_cnt;
    pending_count <= snapshot_q.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Regression for the arcade input sampler: directed corner commands, then
// random command streams with coin press/release sequences across all
// register settings, with random idling on both channels but for the last phase.
// ---------------------------------------------------------------------------
module tb;
  import ais_pkg::*;

  localparam int PHASE_ITEMS       = 240;
  localparam int FIRST_UNUSED_FUNC = FUNC_DRIVE + 1;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] pa;
    logic [BYTE_W-1:0] pb;
    logic [BYTE_W-1:0] pc;
    logic [BYTE_W-1:0] pd;
    logic              swap;
    logic              slot;
    logic [BYTE_W-1:0] amount;
    logic              rapid;
    logic              suppress;
    logic [BYTE_W-1:0] req;
  } sampler_cmd_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  int  fail_count;
  int  pending_count;
  bit  bursty;          // random idling on both channels
  int  cmd_by_func [8];
  int  settings_seen;
  bit  coin_held [2];   // player is holding a coin line down

  ais_in_if  in_ch ();
  ais_out_if out_ch ();

  arcade_input_sampler_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ais_snapshot_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #2000000;
    $display("arcade_input_sampler_top regression: fail");
    $finish;
  end

  // Snapshot sink: ready drops in short random bursts while bursty is set.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (bursty && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // One command transaction: optional idle burst, then hold valid until taken.
  // Valid stays high on return so back-to-back commands need no reassert.
  task automatic push_cmd(input sampler_cmd_t c);
    if (bursty && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.func           <= c.func;
    in_ch.port_a_pins    <= c.pa;
    in_ch.port_b_pins    <= c.pb;
    in_ch.port_c_pins    <= c.pc;
    in_ch.port_d_pins    <= c.pd;
    in_ch.swap_buttons   <= c.swap;
    in_ch.coin_slot      <= c.slot;
    in_ch.coin_amount    <= c.amount;
    in_ch.rapid_enable   <= c.rapid;
    in_ch.rapid_suppress <= c.suppress;
    in_ch.drive_request  <= c.req;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    cmd_by_func[c.func]++;
  endtask

  task automatic send_fields(input logic [FUNC_W-1:0] f,
                             input logic [BYTE_W-1:0] pa, pb, pc, pd,
                             input logic swp, rap, sup, slot,
                             input logic [BYTE_W-1:0] amt, req);
    sampler_cmd_t c;
    c.func = f;   c.pa = pa;     c.pb = pb;       c.pc = pc;
    c.pd = pd;    c.swap = swp;  c.rapid = rap;   c.suppress = sup;
    c.slot = slot; c.amount = amt; c.req = req;
    push_cmd(c);
  endtask

  // Stop sending and wait until every snapshot has been taken. The first
  // edge lets the checker count the last accepted command.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Both registers, back to back; only while the channels are empty.
  task automatic set_mode(input logic mahjong, input logic alt);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAHJONG_MODE;
    cfg_wdata <= mahjong;
    @(posedge clk);
    cfg_index <= CFG_ALT_SWAP;
    cfg_wdata <= alt;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_seen++;
  endtask

  function automatic logic [BYTE_W-1:0] pick_amount();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hff : 8'h00;
    return BYTE_W'($urandom);
  endfunction

  // Mostly plausible play: coin lines follow a held/released pattern that
  // toggles at frame syncs, so releases get counted; some noise on top.
  function automatic sampler_cmd_t random_cmd();
    sampler_cmd_t c;
    int           sel;
    c.pa = BYTE_W'($urandom);  c.pb = BYTE_W'($urandom);
    c.pc = BYTE_W'($urandom);  c.pd = BYTE_W'($urandom);
    c.swap = 1'($urandom);     c.slot = 1'($urandom);
    c.amount = pick_amount();  c.req = BYTE_W'($urandom);
    c.rapid = 1'($urandom);    c.suppress = ($urandom_range(0, 3) == 0);
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      c.func = FUNC_SAMPLE;
      if ($urandom_range(0, 9) != 0) begin
        c.pb[0] = ~coin_held[0];
        c.pc[0] = ~coin_held[1];
      end
    end else if (sel < 70) begin
      c.func = FUNC_SYNC;
      for (int i = 0; i < 2; i++)
        if ($urandom_range(0, 2) == 0) coin_held[i] = ~coin_held[i];
    end else if (sel < 80) begin
      c.func = FUNC_ADD;
    end else if (sel < 90) begin
      c.func = FUNC_SUB;
    end else if (sel < 97) begin
      c.func = FUNC_DRIVE;
    end else begin
      c.func = FUNC_W'($urandom_range(FIRST_UNUSED_FUNC, 7));
    end
    return c;
  endfunction

  task automatic random_phase(input int items);
    for (int n = 0; n < items; n++) begin
      // sender holds off once per phase until the pipe is empty
      if (n == items / 2) drain_results();
      push_cmd(random_cmd());
    end
  endtask

  initial begin
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_MAHJONG_MODE;
    cfg_wdata            <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.func           <= FUNC_SAMPLE;
    in_ch.port_a_pins    <= '1;
    in_ch.port_b_pins    <= '1;
    in_ch.port_c_pins    <= '1;
    in_ch.port_d_pins    <= '1;
    in_ch.swap_buttons   <= 1'b0;
    in_ch.coin_slot      <= 1'b0;
    in_ch.coin_amount    <= '0;
    in_ch.rapid_enable   <= 1'b0;
    in_ch.rapid_suppress <= 1'b0;
    in_ch.drive_request  <= '0;
    bursty        = 1'b1;
    settings_seen = 0;
    coin_held     = '{1'b0, 1'b0};
    foreach (cmd_by_func[i]) cmd_by_func[i] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, standard panel, default swap map ---
    set_mode(1'b0, 1'b0);
    // f, pa, pb, pc, pd, swap, rapid, suppress, slot, amount, req
    send_fields(FUNC_SAMPLE, 8'hff, 8'hff, 8'hff, 8'hff, 0, 0, 0, 0, 8'h00, 8'h00);
    send_fields(FUNC_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00, 0, 1, 0, 0, 8'h00, 8'h00);
    send_fields(FUNC_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00, 1, 1, 1, 0, 8'h00, 8'h00);
    send_fields(FUNC_SAMPLE, 8'h55, 8'haa, 8'h55, 8'hed, 1, 1, 0, 0, 8'h00, 8'h00);
    send_fields(FUNC_SYNC,   8'hff, 8'hff, 8'hff, 8'hff, 0, 0, 0, 0, 8'h00, 8'h00);
    // both coin lines pressed for a frame, then released: one count each
    send_fields(FUNC_SAMPLE, 8'hff, 8'hfe, 8'hfe, 8'hff, 0, 0, 0, 0, 8'h00, 8'h00);
    send_fields(FUNC_SYNC,   8'hff, 8'hff, 8'hff, 8'hff, 0, 0, 0, 0, 8'h00, 8'h00);
    send_fields(FUNC_SAMPLE, 8'hff, 8'hff, 8'hff, 8'hff, 0, 0, 0, 0, 8'h00, 8'h00);
    send_fields(FUNC_SYNC,   8'hff, 8'hff, 8'hff, 8'hff, 0, 0, 0, 0, 8'h00, 8'h00);
    // counter wrap upward and downward
    send_fields(FUNC_ADD,    8'hff, 8'hff, 8'hff, 8'hff, 0, 0, 0, 0, 8'hff, 8'h00);
    send_fields(FUNC_ADD,    8'hff, 8'hff, 8'hff, 8'hff, 0, 0, 0, 0, 8'hff, 8'h00);
    send_fields(FUNC_SUB,    8'hff, 8'hff, 8'hff, 8'hff, 0, 0, 0, 1, 8'hff, 8'h00);
    send_fields(FUNC_SUB,    8'hff, 8'hff, 8'hff, 8'hff, 0, 0, 0, 0, 8'hff, 8'h00);
    // drive request is ignored on the standard panel
    send_fields(FUNC_DRIVE,  8'hff, 8'hff, 8'hff, 8'hff, 0, 0, 0, 0, 8'h00, 8'hff);
    // unused codes only report the snapshot
    for (int k = FIRST_UNUSED_FUNC; k < 8; k++)
      send_fields(FUNC_W'(k), 8'h00, 8'h00, 8'h00, 8'h00, 1, 1, 0, 1, 8'hff, 8'hff);

    // --- directed, mahjong panel, alternate swap map ---
    set_mode(1'b1, 1'b1);
    send_fields(FUNC_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00, 1, 1, 0, 0, 8'h00, 8'h00);
    send_fields(FUNC_DRIVE,  8'hff, 8'hff, 8'hff, 8'hff, 0, 0, 0, 0, 8'h00, 8'hff);
    send_fields(FUNC_DRIVE,  8'hff, 8'hff, 8'hff, 8'hff, 0, 0, 0, 0, 8'h00, 8'h5a);
    send_fields(FUNC_DRIVE,  8'hff, 8'hff, 8'hff, 8'hff, 0, 0, 0, 0, 8'h00, 8'h0f);
    send_fields(FUNC_SAMPLE, 8'h3c, 8'h81, 8'h42, 8'h00, 1, 1, 0, 0, 8'h00, 8'h00);

    // --- random phases across every register setting ---
    set_mode(1'b0, 1'b1);
    random_phase(PHASE_ITEMS);
    set_mode(1'b1, 1'b0);
    random_phase(PHASE_ITEMS);
    set_mode(1'b0, 1'b0);
    random_phase(PHASE_ITEMS);
    set_mode(1'b1, 1'b1);
    random_phase(PHASE_ITEMS);

    // last stretch at full rate on both sides
    set_mode(1'b0, 1'b0);
    bursty = 1'b0;
    random_phase(PHASE_ITEMS);

    drain_results();
    repeat (8) @(posedge clk);

    $display("%0d commands: %0d samples, %0d syncs, %0d adds, %0d subtracts, %0d drives",
             cmd_by_func.sum(), cmd_by_func[FUNC_SAMPLE], cmd_by_func[FUNC_SYNC],
             cmd_by_func[FUNC_ADD], cmd_by_func[FUNC_SUB], cmd_by_func[FUNC_DRIVE]);
    $display("%0d unused-code commands, %0d register settings, %0d mismatches",
             cmd_by_func[5] + cmd_by_func[6] + cmd_by_func[7], settings_seen, fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("arcade_input_sampler_top regression: pass");
    end else begin
      $display("arcade_input_sampler_top regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/ais_pkg.sv
src/ais_in_if.sv
src/ais_out_if.sv
src/arcade_input_sampler_top.sv
tb/ais_snapshot_checker.sv
tb/tb.sv
